[src/blzd_pkg.sv]
// ----------------------------------------------------------------------------
// blzd_pkg
// Types, command and status bundles and code tables for the backward
// lz bitstream depacker.
// ----------------------------------------------------------------------------
package blzd_pkg;

    localparam int POS_W = 24;
    localparam int CFG_W = 24;

    typedef struct packed {
        logic       start_req;
        logic       has_byte;
        logic [7:0] packed_byte;
    } t_in;

    typedef struct packed {
        logic              out_valid;
        logic [7:0]        out_byte;
        logic [POS_W-1:0]  out_position;
        logic              byte_taken;
        logic              finished;
        logic              error_flag;
    } t_out;

    typedef enum logic [2:0] {
        FLD_NONE,
        FLD_LIT0,
        FLD_LITNEXT,
        FLD_LEN,
        FLD_OFF,
        FLD_OFF2
    } t_fld;

    typedef struct packed {
        logic accept;
        logic start;
        logic prime;
        logic take_bit;
        logic shift_acc;
        t_fld fld;
        logic pstep_clr;
        logic pstep_inc;
        logic set_litrun;
        logic set_lenrun;
        logic set_dist;
        logic ram_rd;
        logic emit_lit;
        logic emit_ram;
        logic finish;
        logic done_f;
        logic err_f;
    } t_cmd;

    typedef struct packed {
        logic       bit_ok;
        logic       bit_val;
        logic       avail;
        logic       field_done;
        logic       lit_match;
        logic [2:0] pstep;
        logic       run_is2;
        logic       run_last;
        logic       lit_over;
        logic       ref_err;
        logic       rem_zero;
    } t_stat;

    // literal length groups
    function automatic logic [3:0] f_lit_width(input logic [2:0] i);
        case (i)
            3'd0:    f_lit_width = 4'd1;
            3'd1:    f_lit_width = 4'd2;
            3'd2:    f_lit_width = 4'd2;
            3'd3:    f_lit_width = 4'd3;
            3'd4:    f_lit_width = 4'd8;
            3'd5:    f_lit_width = 4'd15;
            default: f_lit_width = 4'd0;
        endcase
    endfunction

    function automatic logic [15:0] f_lit_ones(input logic [2:0] i);
        case (i)
            3'd0:    f_lit_ones = 16'h0001;
            3'd1:    f_lit_ones = 16'h0003;
            3'd2:    f_lit_ones = 16'h0003;
            3'd3:    f_lit_ones = 16'h0007;
            3'd4:    f_lit_ones = 16'h00ff;
            3'd5:    f_lit_ones = 16'h7fff;
            default: f_lit_ones = 16'h0000;
        endcase
    endfunction

    function automatic logic [8:0] f_lit_add(input logic [2:0] i);
        case (i)
            3'd0:    f_lit_add = 9'd1;
            3'd1:    f_lit_add = 9'd2;
            3'd2:    f_lit_add = 9'd5;
            3'd3:    f_lit_add = 9'd8;
            3'd4:    f_lit_add = 9'd15;
            default: f_lit_add = 9'd270;
        endcase
    endfunction

    function automatic logic [3:0] f_len_width(input logic [2:0] i);
        case (i)
            3'd2:    f_len_width = 4'd1;
            3'd3:    f_len_width = 4'd2;
            3'd4:    f_len_width = 4'd10;
            default: f_len_width = 4'd0;
        endcase
    endfunction

    function automatic logic [3:0] f_len_add(input logic [2:0] i);
        case (i)
            3'd0:    f_len_add = 4'd2;
            3'd1:    f_len_add = 4'd3;
            3'd2:    f_len_add = 4'd4;
            3'd3:    f_len_add = 4'd6;
            default: f_len_add = 4'd10;
        endcase
    endfunction

    // distance forms: 0..2 long, 3 and 4 for length two
    function automatic logic [3:0] f_off_width(input logic [2:0] i);
        case (i)
            3'd0:    f_off_width = 4'd8;
            3'd1:    f_off_width = 4'd5;
            3'd2:    f_off_width = 4'd12;
            3'd3:    f_off_width = 4'd6;
            default: f_off_width = 4'd9;
        endcase
    endfunction

    function automatic logic [8:0] f_off_base(input logic [2:0] i);
        case (i)
            3'd0:    f_off_base = 9'd32;
            3'd1:    f_off_base = 9'd0;
            3'd2:    f_off_base = 9'd288;
            3'd3:    f_off_base = 9'd0;
            default: f_off_base = 9'd64;
        endcase
    endfunction

endpackage

[src/blzd_ram.sv]
// ----------------------------------------------------------------------------
// blzd_ram
// Generic single write port ram with registered read.
// ----------------------------------------------------------------------------
module blzd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

[src/blzd_dp.sv]
// ----------------------------------------------------------------------------
// blzd_dp
// Datapath: bit buffer, field accumulator, counters, history window and
// result register.
// ----------------------------------------------------------------------------
module blzd_dp
    import blzd_pkg::*;
#(
    parameter int WINDOW_DEPTH = 8192,
    parameter int LENGTH_BITS  = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  t_in              i_in,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    output t_out             o_out
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = LENGTH_BITS + 18;

    logic [LENGTH_BITS-1:0] r_ulen, r_image, r_rem, n_image, n_rem;
    logic [7:0]             r_bitbuf, n_bitbuf, r_offered, n_offered;
    logic [15:0]            r_run, n_run, r_acc, n_acc;
    logic [12:0]            r_dist, n_dist;
    logic [2:0]             r_pstep, n_pstep;
    logic [3:0]             r_bleft, n_bleft;
    logic                   r_avail, n_avail;
    logic                   r_res_valid, n_res_valid, r_res_taken, n_res_taken;
    logic [7:0]             r_res_byte, n_res_byte;
    logic [POS_W-1:0]       r_res_pos, n_res_pos;

    logic [LENGTH_BITS-1:0] rem_m1;
    logic                   bit_low;
    logic [15:0]            run_lit;
    logic [16:0]            sum_ab, dist_full;
    logic [2:0]             off2_step;
    logic                   ram_we;
    logic [7:0]             ram_wdata, ram_rdata;
    logic [AW-1:0]          ram_raddr;

    assign rem_m1    = r_rem - 1'b1;
    assign bit_low   = (r_bitbuf[6:0] != 7'd0);
    assign run_lit   = r_acc + 16'(f_lit_add(r_pstep));
    assign sum_ab    = 17'(r_acc) + 17'(f_off_base(r_pstep));
    assign dist_full = (sum_ab == 17'd0) ? 17'd1 : (sum_ab - 17'd1 + 17'(r_run));
    assign off2_step = o_stat.bit_val ? 3'd4 : 3'd3;
    assign ram_raddr = AW'(rem_m1 + LENGTH_BITS'(r_dist));

    always_comb begin
        o_stat.bit_ok     = bit_low | r_avail;
        o_stat.bit_val    = bit_low ? r_bitbuf[7] : r_offered[7];
        o_stat.avail      = r_avail;
        o_stat.field_done = (r_bleft == 4'd0);
        o_stat.lit_match  = (r_pstep < 3'd6) && (r_acc == f_lit_ones(r_pstep));
        o_stat.pstep      = r_pstep;
        o_stat.run_is2    = (r_run == 16'd2);
        o_stat.run_last   = (r_run == 16'd1);
        o_stat.lit_over   = CW'(run_lit) > CW'(r_rem);
        o_stat.ref_err    = (CW'(r_run) > CW'(r_rem)) ||
                            ((CW'(rem_m1) + CW'(dist_full)) >= CW'(r_image));
        o_stat.rem_zero   = (r_rem == '0);
    end

    always_comb begin
        n_image     = r_image;
        n_rem       = r_rem;
        n_bitbuf    = r_bitbuf;
        n_offered   = r_offered;
        n_run       = r_run;
        n_acc       = r_acc;
        n_dist      = r_dist;
        n_pstep     = r_pstep;
        n_bleft     = r_bleft;
        n_avail     = r_avail;
        n_res_valid = r_res_valid;
        n_res_taken = r_res_taken;
        n_res_byte  = r_res_byte;
        n_res_pos   = r_res_pos;
        ram_we      = 1'b0;
        ram_wdata   = r_offered;

        if (i_cmd.accept) begin
            n_avail     = i_in.has_byte;
            n_offered   = i_in.packed_byte;
            n_res_valid = 1'b0;
            n_res_taken = 1'b0;
            n_res_byte  = '0;
            n_res_pos   = '0;
        end
        if (i_cmd.start) begin
            n_image  = r_ulen;
            n_rem    = r_ulen;
            n_run    = '0;
            n_dist   = '0;
            n_acc    = '0;
            n_pstep  = '0;
            n_bleft  = '0;
            n_bitbuf = '0;
        end
        if (i_cmd.prime) begin
            n_bitbuf    = r_offered;
            n_avail     = 1'b0;
            n_res_taken = 1'b1;
        end
        if (i_cmd.take_bit) begin
            if (bit_low) begin
                n_bitbuf = {r_bitbuf[6:0], 1'b0};
            end else begin
                // refill with sentinel
                n_bitbuf    = {r_offered[6:0], 1'b1};
                n_avail     = 1'b0;
                n_res_taken = 1'b1;
            end
        end
        if (i_cmd.shift_acc) begin
            n_acc   = {r_acc[14:0], o_stat.bit_val};
            n_bleft = r_bleft - 4'd1;
        end
        case (i_cmd.fld)
            FLD_LIT0: begin
                n_pstep = 3'd0;
                n_acc   = '0;
                n_bleft = f_lit_width(3'd0);
            end
            FLD_LITNEXT: begin
                n_pstep = r_pstep + 3'd1;
                n_acc   = '0;
                n_bleft = f_lit_width(r_pstep + 3'd1);
            end
            FLD_LEN: begin
                n_acc   = '0;
                n_bleft = f_len_width(r_pstep);
            end
            FLD_OFF: begin
                n_acc   = '0;
                n_bleft = f_off_width(r_pstep);
            end
            FLD_OFF2: begin
                n_pstep = off2_step;
                n_acc   = '0;
                n_bleft = f_off_width(off2_step);
            end
            default: begin
            end
        endcase
        if (i_cmd.pstep_clr) begin
            n_pstep = '0;
        end
        if (i_cmd.pstep_inc) begin
            n_pstep = r_pstep + 3'd1;
        end
        if (i_cmd.set_litrun) begin
            n_run = run_lit;
        end
        if (i_cmd.set_lenrun) begin
            n_run   = r_acc + 16'(f_len_add(r_pstep));
            n_pstep = '0;
        end
        if (i_cmd.set_dist) begin
            n_dist = dist_full[12:0];
        end
        if (i_cmd.emit_lit || i_cmd.emit_ram) begin
            ram_we      = 1'b1;
            ram_wdata   = i_cmd.emit_ram ? ram_rdata : r_offered;
            n_res_valid = 1'b1;
            n_res_byte  = ram_wdata;
            n_res_pos   = POS_W'(rem_m1);
            n_rem       = rem_m1;
            n_run       = r_run - 16'd1;
        end
        if (i_cmd.emit_lit) begin
            n_avail     = 1'b0;
            n_res_taken = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ulen      <= '0;
            r_image     <= '0;
            r_rem       <= '0;
            r_bitbuf    <= '0;
            r_run       <= '0;
            r_acc       <= '0;
            r_dist      <= '0;
            r_pstep     <= '0;
            r_bleft     <= '0;
            r_avail     <= 1'b0;
            r_res_valid <= 1'b0;
            r_res_taken <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ulen <= LENGTH_BITS'(i_cfg_wdata);
            end
            r_image     <= n_image;
            r_rem       <= n_rem;
            r_bitbuf    <= n_bitbuf;
            r_run       <= n_run;
            r_acc       <= n_acc;
            r_dist      <= n_dist;
            r_pstep     <= n_pstep;
            r_bleft     <= n_bleft;
            r_avail     <= n_avail;
            r_res_valid <= n_res_valid;
            r_res_taken <= n_res_taken;
        end
    end

    always_ff @(posedge i_clk) begin
        r_offered  <= n_offered;
        r_res_byte <= n_res_byte;
        r_res_pos  <= n_res_pos;
        if (i_cmd.finish) begin
            o_out.out_valid    <= n_res_valid;
            o_out.out_byte     <= n_res_byte;
            o_out.out_position <= n_res_pos;
            o_out.byte_taken   <= n_res_taken;
            o_out.finished     <= i_cmd.done_f;
            o_out.error_flag   <= i_cmd.err_f;
        end
    end

    blzd_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(rem_m1)),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.ram_rd),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

[src/blzd_ctrl.sv]
// ----------------------------------------------------------------------------
// blzd_ctrl
// Controller: decode phase sequencing and request handshakes.
// ----------------------------------------------------------------------------
module blzd_ctrl
    import blzd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_in   i_in,
    output logic  o_in_stall,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_PRIME    = 4'd1;
    localparam logic [3:0] PH_PICK     = 4'd2;
    localparam logic [3:0] PH_LITLEN   = 4'd3;
    localparam logic [3:0] PH_LITCOPY  = 4'd4;
    localparam logic [3:0] PH_CHECK    = 4'd5;
    localparam logic [3:0] PH_REFPRE   = 4'd6;
    localparam logic [3:0] PH_REFFIELD = 4'd7;
    localparam logic [3:0] PH_OFFSEL   = 4'd8;
    localparam logic [3:0] PH_OFFFIELD = 4'd9;
    localparam logic [3:0] PH_REFCOPY  = 4'd10;
    localparam logic [3:0] PH_DONE     = 4'd11;
    localparam logic [3:0] PH_ERROR    = 4'd12;
    localparam logic [3:0] PH_REFRD    = 4'd13;

    logic [3:0] r_phase, n_phase;
    logic       r_busy, n_busy, r_ovalid, n_ovalid;
    logic       accept, end_item;

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_ovalid;
    assign accept      = i_in_valid & ~o_in_stall;

    always_comb begin
        n_phase  = r_phase;
        o_cmd    = '0;
        end_item = 1'b0;
        if (accept) begin
            o_cmd.accept = 1'b1;
            if (i_in.start_req) begin
                o_cmd.start = 1'b1;
                n_phase     = PH_PRIME;
            end
        end else if (r_busy && !(r_ovalid && i_out_stall)) begin
            // decoding holds while the last result is still stalled
            case (r_phase)
                PH_PRIME: begin
                    if (i_stat.avail) begin
                        o_cmd.prime = 1'b1;
                        n_phase     = PH_PICK;
                    end
                    end_item = 1'b1;
                end
                PH_PICK: begin
                    if (!i_stat.bit_ok) begin
                        end_item = 1'b1;
                    end else begin
                        o_cmd.take_bit = 1'b1;
                        if (i_stat.bit_val) begin
                            o_cmd.fld = FLD_LIT0;
                            n_phase   = PH_LITLEN;
                        end else begin
                            n_phase = PH_CHECK;
                        end
                    end
                end
                PH_LITLEN, PH_REFFIELD, PH_OFFFIELD: begin
                    if (!i_stat.field_done) begin
                        if (!i_stat.bit_ok) begin
                            end_item = 1'b1;
                        end else begin
                            o_cmd.take_bit  = 1'b1;
                            o_cmd.shift_acc = 1'b1;
                        end
                    end else if (r_phase == PH_LITLEN) begin
                        // an all-ones group other than the last moves on to the next group
                        if (i_stat.lit_match && (i_stat.pstep < 3'd5)) begin
                            o_cmd.fld = FLD_LITNEXT;
                        end else begin
                            o_cmd.set_litrun = 1'b1;
                            n_phase = i_stat.lit_over ? PH_ERROR : PH_LITCOPY;
                        end
                    end else if (r_phase == PH_REFFIELD) begin
                        o_cmd.set_lenrun = 1'b1;
                        n_phase          = PH_OFFSEL;
                    end else begin
                        o_cmd.set_dist = 1'b1;
                        n_phase        = i_stat.ref_err ? PH_ERROR : PH_REFCOPY;
                    end
                end
                PH_LITCOPY: begin
                    if (i_stat.avail) begin
                        o_cmd.emit_lit = 1'b1;
                        if (i_stat.run_last) begin
                            n_phase = PH_CHECK;
                        end
                    end
                    end_item = 1'b1;
                end
                PH_CHECK: begin
                    if (!i_stat.rem_zero) begin
                        o_cmd.pstep_clr = 1'b1;
                        n_phase         = PH_REFPRE;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_REFPRE: begin
                    if (i_stat.pstep < 3'd4) begin
                        if (!i_stat.bit_ok) begin
                            end_item = 1'b1;
                        end else begin
                            o_cmd.take_bit = 1'b1;
                            if (i_stat.bit_val) begin
                                o_cmd.pstep_inc = 1'b1;
                            end else begin
                                o_cmd.fld = FLD_LEN;
                                n_phase   = PH_REFFIELD;
                            end
                        end
                    end else begin
                        o_cmd.fld = FLD_LEN;
                        n_phase   = PH_REFFIELD;
                    end
                end
                PH_OFFSEL: begin
                    if (i_stat.run_is2) begin
                        if (!i_stat.bit_ok) begin
                            end_item = 1'b1;
                        end else begin
                            o_cmd.take_bit = 1'b1;
                            o_cmd.fld      = FLD_OFF2;
                            n_phase        = PH_OFFFIELD;
                        end
                    end else if (i_stat.pstep < 3'd2) begin
                        if (!i_stat.bit_ok) begin
                            end_item = 1'b1;
                        end else begin
                            o_cmd.take_bit = 1'b1;
                            if (i_stat.bit_val) begin
                                o_cmd.pstep_inc = 1'b1;
                            end else begin
                                o_cmd.fld = FLD_OFF;
                                n_phase   = PH_OFFFIELD;
                            end
                        end
                    end else begin
                        o_cmd.fld = FLD_OFF;
                        n_phase   = PH_OFFFIELD;
                    end
                end
                PH_REFCOPY: begin
                    o_cmd.ram_rd = 1'b1;
                    n_phase      = PH_REFRD;
                end
                PH_REFRD: begin
                    o_cmd.emit_ram = 1'b1;
                    n_phase        = i_stat.run_last ? PH_PICK : PH_REFCOPY;
                    end_item       = 1'b1;
                end
                default: begin
                    end_item = 1'b1;
                end
            endcase
        end
        o_cmd.finish = end_item;
        o_cmd.done_f = (n_phase == PH_DONE);
        o_cmd.err_f  = (n_phase == PH_ERROR);
    end

    always_comb begin
        n_busy   = r_busy;
        n_ovalid = r_ovalid;
        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end
        if (accept) begin
            n_busy = 1'b1;
        end else if (end_item) begin
            n_busy   = 1'b0;
            n_ovalid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

[src/backward_lz_bitstream_depacker.sv]
// decoding: after a request is accepted, the controller runs one decode step at a
// time (one bit, one field finish or one phase change) up to its result, with a
// window ram read before each copied byte
// requests: one at a time, the next taken while the last result waits
// reset: synchronous active low, clears control and decode state; window undefined
// ----------------------------------------------------------------------------
// backward_lz_bitstream_depacker
// Backward lz depacker top level: controller, datapath and window ram.
// ----------------------------------------------------------------------------
module backward_lz_bitstream_depacker
    import blzd_pkg::*;
#(
    parameter int WINDOW_DEPTH = 8192,
    parameter int LENGTH_BITS  = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in              i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out             o_out,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    t_cmd  cmd;
    t_stat stat;

    blzd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    blzd_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .LENGTH_BITS  (LENGTH_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out       (o_out)
    );

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("not busy after accepting a request");

    a_done_err_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.finished && o_out.error_flag))
        else $error("finished and error both set");
`endif

endmodule

[sim/blzd_checker.sv]
// ----------------------------------------------------------------------------
// blzd_checker
// Watches both channels and the register port of the depacker. It keeps its
// own model of the decoder, works out the result of every accepted request
// and compares each delivered result with the oldest one waiting.
// ----------------------------------------------------------------------------
module blzd_checker
    import blzd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  t_in              i_in,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  t_out             i_out,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_result_count
);

    localparam int WIN = 8192;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PRIME, ST_PICK, ST_LITLEN, ST_LITCOPY, ST_CHECK, ST_REFPRE,
        ST_REFFIELD, ST_OFFSEL, ST_OFFFIELD, ST_REFCOPY, ST_DONE, ST_ERR
    } t_phase;

    logic [7:0] image_ram [0:WIN-1];
    logic [7:0] bitbuf;
    longint     remaining;
    longint     img_len;
    longint     cfg_len;
    t_phase     phase;
    int         run_cnt;
    int         copy_dist;
    int         acc;
    int         pstep;
    int         field_bits;
    bit         avail_b;
    logic [7:0] offer_b;
    t_out       res;
    t_out       expected_q [$];
    int         fails;
    int         results;

    function automatic int lit_grp_width(input int i);
        case (i)
            0:       return 1;
            1, 2:    return 2;
            3:       return 3;
            4:       return 8;
            default: return 15;
        endcase
    endfunction

    function automatic int lit_grp_ones(input int i);
        case (i)
            0:       return 1;
            1, 2:    return 3;
            3:       return 7;
            4:       return 255;
            default: return 32767;
        endcase
    endfunction

    function automatic int lit_grp_base(input int i);
        case (i)
            0:       return 1;
            1:       return 2;
            2:       return 5;
            3:       return 8;
            4:       return 15;
            default: return 270;
        endcase
    endfunction

    function automatic int ref_len_width(input int i);
        case (i)
            2:       return 1;
            3:       return 2;
            4:       return 10;
            default: return 0;
        endcase
    endfunction

    function automatic int ref_len_base(input int i);
        case (i)
            0:       return 2;
            1:       return 3;
            2:       return 4;
            3:       return 6;
            default: return 10;
        endcase
    endfunction

    function automatic int dist_width(input int i);
        case (i)
            0:       return 8;
            1:       return 5;
            2:       return 12;
            3:       return 6;
            default: return 9;
        endcase
    endfunction

    function automatic int dist_base(input int i);
        case (i)
            0:       return 32;
            2:       return 288;
            4:       return 64;
            default: return 0;
        endcase
    endfunction

    // sentinel left alone means the next packed byte refills the buffer
    function automatic bit pull_bit(output bit b);
        b = 1'b0;
        if (bitbuf[6:0] == 7'd0) begin
            if (!avail_b) return 1'b0;
            avail_b = 1'b0;
            res.byte_taken = 1'b1;
            b = offer_b[7];
            bitbuf = {offer_b[6:0], 1'b1};
        end else begin
            b = bitbuf[7];
            bitbuf = {bitbuf[6:0], 1'b0};
        end
        return 1'b1;
    endfunction

    function automatic bit shift_field();
        bit b;
        while (field_bits > 0) begin
            if (!pull_bit(b)) return 1'b0;
            acc = ((acc << 1) | b) & 16'hffff;
            field_bits--;
        end
        return 1'b1;
    endfunction

    function automatic void open_field(input int n);
        field_bits = n;
        acc = 0;
    endfunction

    function automatic void put_out(input logic [7:0] v);
        longint pos;
        pos = remaining - 1;
        image_ram[int'(pos % WIN)] = v;
        res.out_valid = 1'b1;
        res.out_byte = v;
        res.out_position = pos[POS_W-1:0];
        remaining--;
        run_cnt--;
    endfunction

    // one decode action, returns 1 when the request is finished
    function automatic bit decode_step();
        bit     b;
        int     i;
        longint d;
        case (phase)
            ST_PRIME: begin
                if (!avail_b) return 1'b1;
                avail_b = 1'b0;
                res.byte_taken = 1'b1;
                bitbuf = offer_b;
                phase = ST_PICK;
                return 1'b1;
            end
            ST_PICK: begin
                if (!pull_bit(b)) return 1'b1;
                if (b) begin
                    pstep = 0;
                    open_field(lit_grp_width(0));
                    phase = ST_LITLEN;
                end else begin
                    phase = ST_CHECK;
                end
                return 1'b0;
            end
            ST_LITLEN: begin
                if (!shift_field()) return 1'b1;
                i = pstep;
                if (i < 6 && acc == lit_grp_ones(i)) begin
                    i++;
                    pstep = i;
                    if (i < 6) begin
                        open_field(lit_grp_width(i));
                        return 1'b0;
                    end
                end
                run_cnt = (acc + lit_grp_base(i)) & 16'hffff;
                phase = (longint'(run_cnt) > remaining) ? ST_ERR : ST_LITCOPY;
                return 1'b0;
            end
            ST_LITCOPY: begin
                if (!avail_b) return 1'b1;
                avail_b = 1'b0;
                res.byte_taken = 1'b1;
                put_out(offer_b);
                if (run_cnt == 0) phase = ST_CHECK;
                return 1'b1;
            end
            ST_CHECK: begin
                if (remaining > 0) begin
                    pstep = 0;
                    phase = ST_REFPRE;
                end else begin
                    phase = ST_DONE;
                end
                return 1'b0;
            end
            ST_REFPRE: begin
                if (pstep < 4) begin
                    if (!pull_bit(b)) return 1'b1;
                    if (b) begin
                        pstep++;
                        return 1'b0;
                    end
                end
                open_field(ref_len_width(pstep));
                phase = ST_REFFIELD;
                return 1'b0;
            end
            ST_REFFIELD: begin
                if (!shift_field()) return 1'b1;
                run_cnt = acc + ref_len_base(pstep);
                pstep = 0;
                phase = ST_OFFSEL;
                return 1'b0;
            end
            ST_OFFSEL: begin
                if (run_cnt == 2) begin
                    if (!pull_bit(b)) return 1'b1;
                    pstep = b ? 4 : 3;
                end else if (pstep < 2) begin
                    if (!pull_bit(b)) return 1'b1;
                    if (b) begin
                        pstep++;
                        return 1'b0;
                    end
                end
                open_field(dist_width(pstep));
                phase = ST_OFFFIELD;
                return 1'b0;
            end
            ST_OFFFIELD: begin
                if (!shift_field()) return 1'b1;
                if (acc + dist_base(pstep) == 0) d = 1;
                else d = longint'(acc) + dist_base(pstep) - 1 + run_cnt;
                copy_dist = int'(d & 64'h1fff);
                if (longint'(run_cnt) > remaining || remaining - 1 + d >= img_len)
                    phase = ST_ERR;
                else
                    phase = ST_REFCOPY;
                return 1'b0;
            end
            ST_REFCOPY: begin
                d = remaining - 1 + copy_dist;
                put_out(image_ram[int'(d % WIN)]);
                if (run_cnt == 0) phase = ST_PICK;
                return 1'b1;
            end
            default: return 1'b1;
        endcase
    endfunction

    function automatic t_out predict_result(input t_in x);
        res = '0;
        avail_b = x.has_byte;
        offer_b = x.packed_byte;
        if (x.start_req) begin
            img_len = cfg_len;
            remaining = cfg_len;
            run_cnt = 0;
            copy_dist = 0;
            acc = 0;
            pstep = 0;
            field_bits = 0;
            bitbuf = 8'h00;
            phase = ST_PRIME;
            void'(decode_step());
        end else begin
            while (!decode_step()) ;
        end
        res.finished = (phase == ST_DONE);
        res.error_flag = (phase == ST_ERR);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            bitbuf = 8'h00;
            remaining = 0;
            img_len = 0;
            cfg_len = 0;
            phase = ST_IDLE;
            run_cnt = 0;
            copy_dist = 0;
            acc = 0;
            pstep = 0;
            field_bits = 0;
        end else begin
            if (i_cfg_we) cfg_len = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) expected_q.push_back(predict_result(i_in));
            if (i_out_valid && !i_out_stall) begin
                results++;
                if (expected_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result %0d with no request waiting", results);
                end else begin
                    want = expected_q.pop_front();
                    if (i_out.out_valid !== want.out_valid
                        || i_out.out_byte !== want.out_byte
                        || i_out.out_position !== want.out_position
                        || i_out.byte_taken !== want.byte_taken
                        || i_out.finished !== want.finished
                        || i_out.error_flag !== want.error_flag) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("result %0d want v=%0d b=%h p=%0d t=%0d f=%0d e=%0d",
                                     results, want.out_valid, want.out_byte,
                                     want.out_position, want.byte_taken,
                                     want.finished, want.error_flag);
                            $display("result %0d got  v=%0d b=%h p=%0d t=%0d f=%0d e=%0d",
                                     results, i_out.out_valid, i_out.out_byte,
                                     i_out.out_position, i_out.byte_taken,
                                     i_out.finished, i_out.error_flag);
                        end
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending <= expected_q.size();
        o_result_count <= results;
    end

endmodule

[sim/tb_backward_lz_bitstream_depacker.sv]
// ----------------------------------------------------------------------------
// tb_backward_lz_bitstream_depacker
// Encodes random packed images bit by bit into request sequences, mixed with
// faulty streams and noise, and drives them through the depacker with random
// gaps and stalls. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_backward_lz_bitstream_depacker;
    import blzd_pkg::*;

    localparam int EV_BUF = 0;
    localparam int EV_REFILL = 1;
    localparam int EV_LIT = 2;
    localparam int EV_COPY = 3;

    localparam int MODE_CLEAN = 0;
    localparam int MODE_LIT_OVER = 1;
    localparam int MODE_REF_FAR = 2;
    localparam int MODE_TAIL_LIT = 3;
    localparam int MODE_CORRUPT = 4;

    localparam int TARGET_REQS = 1750;
    localparam int IDLE_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 40;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    t_in              in_req;
    logic             out_valid;
    logic             out_stall;
    t_out             out_res;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    int               fail_count;
    int               pending;
    int               result_count;

    logic [7:0] packed_q [$];
    int         ev_kind [$];
    int         ev_slot [$];
    t_in        stim_q [$];
    int         fill;
    int         cur_slot;
    int         sent;
    int         idle_cycles;
    int         n_clean;
    int         n_faulty;
    int         n_noise;
    bit         hold_rx;
    bit         no_idle;

    backward_lz_bitstream_depacker dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_res),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    blzd_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in           (in_req),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out          (out_res),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL backward_lz_bitstream_depacker");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver side, one long hold once asked for
    initial begin
        int n;
        bit held;
        held = 1'b0;
        out_stall <= 1'b0;
        forever begin
            if (hold_rx && !held) begin
                n = 200;
                held = 1'b1;
            end else if (no_idle) n = 0;
            else n = $urandom_range(0, 4);
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
        end
    end

    function automatic t_in mk_req(input bit s, input bit h, input logic [7:0] b);
        t_in x;
        x.start_req = s;
        x.has_byte = h;
        x.packed_byte = b;
        return x;
    endfunction

    function automatic int min_of(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

    // bits fill packed bytes msb first; a fresh byte is read at its first bit
    task automatic put_bit(input bit b);
        logic [7:0] tmp;
        if (fill == 0) begin
            packed_q.push_back(8'h00);
            cur_slot = packed_q.size() - 1;
            ev_kind.push_back(EV_REFILL);
            ev_slot.push_back(cur_slot);
        end else begin
            ev_kind.push_back(EV_BUF);
            ev_slot.push_back(0);
        end
        tmp = packed_q[cur_slot];
        tmp[7 - fill] = b;
        packed_q[cur_slot] = tmp;
        fill = (fill + 1) % 8;
    endtask

    task automatic put_bits(input int v, input int n);
        for (int i = n - 1; i >= 0; i--) put_bit(1'((v >> i) & 1));
    endtask

    task automatic put_literal(input logic [7:0] v);
        packed_q.push_back(v);
        ev_kind.push_back(EV_LIT);
        ev_slot.push_back(packed_q.size() - 1);
    endtask

    task automatic put_lit_len(input int l);
        put_bits(l == 1 ? 0 : 1, 1);
        if (l == 1) return;
        if (l <= 4) begin
            put_bits(l - 2, 2);
            return;
        end
        put_bits(3, 2);
        if (l <= 7) begin
            put_bits(l - 5, 2);
            return;
        end
        put_bits(3, 2);
        if (l <= 14) begin
            put_bits(l - 8, 3);
            return;
        end
        put_bits(7, 3);
        if (l <= 269) begin
            put_bits(l - 15, 8);
            return;
        end
        put_bits(255, 8);
        put_bits(l - 270, 15);
    endtask

    // back-reference: length code, distance code, then one emit per byte
    task automatic put_copy(input int run, input int w, input bit far);
        if (run == 2) put_bits(0, 1);
        else if (run == 3) put_bits(2, 2);
        else if (run <= 5) begin
            put_bits(6, 3);
            put_bits(run - 4, 1);
        end else if (run <= 9) begin
            put_bits(14, 4);
            put_bits(run - 6, 2);
        end else begin
            put_bits(15, 4);
            put_bits(run - 10, 10);
        end
        if (run == 2) begin
            if (far) begin
                put_bit(1);
                put_bits(511, 9);
            end else if (w >= 65 && $urandom_range(0, 1)) begin
                put_bit(1);
                put_bits($urandom_range(0, min_of(511, w - 65)), 9);
            end else begin
                put_bit(0);
                put_bits($urandom_range(0, min_of(63, w - 1)), 6);
            end
        end else if (far) begin
            put_bits(3, 2);
            put_bits(4095, 12);
        end else if (w - 287 - run >= 0 && $urandom_range(0, 2) == 0) begin
            put_bits(3, 2);
            put_bits($urandom_range(0, min_of(4095, w - 287 - run)), 12);
        end else if (w - 31 - run >= 0 && $urandom_range(0, 1)) begin
            put_bit(0);
            put_bits($urandom_range(0, min_of(255, w - 31 - run)), 8);
        end else begin
            put_bits(2, 2);
            put_bits($urandom_range(0, (w - run + 1 < 1) ? 0 : min_of(31, w - run + 1)), 5);
        end
        repeat (run) begin
            ev_kind.push_back(EV_COPY);
            ev_slot.push_back(0);
        end
    endtask

    task automatic encode_image(input int n, input int mode, input int cap_lit,
                                input int cap_run);
        int rem;
        int l;
        int run;
        bit at_pick;
        packed_q.delete();
        ev_kind.delete();
        ev_slot.delete();
        fill = 0;
        rem = n;
        at_pick = 1'b1;
        if (mode == MODE_LIT_OVER) begin
            put_bit(1);
            put_lit_len(rem + $urandom_range(1, 3));
            return;
        end
        while (rem > 0) begin
            if (at_pick) begin
                if (rem == n || rem == 1 || $urandom_range(0, 1)) begin
                    put_bit(1);
                    l = $urandom_range(1, min_of(rem, cap_lit));
                    // a single byte left over could not be copied
                    if (rem - l == 1) l = (l > 1) ? l - 1 : rem;
                    put_lit_len(l);
                    repeat (l) put_literal(8'($urandom_range(0, 255)));
                    rem -= l;
                    at_pick = 1'b0;
                    if (rem == 0) break;
                end else begin
                    put_bit(0);
                end
            end
            run = $urandom_range(2, min_of(rem, cap_run));
            put_copy(run, n - rem, mode == MODE_REF_FAR);
            if (mode == MODE_REF_FAR) return;
            rem -= run;
            at_pick = 1'b1;
        end
        if (at_pick) begin
            put_bit(mode == MODE_TAIL_LIT);
            if (mode == MODE_TAIL_LIT) put_bit(0);
        end
        if (mode == MODE_CORRUPT && packed_q.size() > 0) begin
            l = $urandom_range(0, packed_q.size() - 1);
            packed_q[l] = packed_q[l] ^ (8'h01 << $urandom_range(0, 7));
        end
    endtask

    // cut the event list into requests: each takes one byte and emits one byte at most
    task automatic build_requests(input bit start_with_byte);
        bit         has;
        bit         open;
        logic [7:0] byt;
        stim_q.delete();
        has = 1'b0;
        open = 1'b0;
        byt = 8'h00;
        if (start_with_byte) begin
            stim_q.push_back(mk_req(1'b1, 1'b1, 8'h80));
        end else begin
            stim_q.push_back(mk_req(1'b1, 1'b0, 8'($urandom_range(0, 255))));
            stim_q.push_back(mk_req(1'b0, 1'b1, 8'h80));
        end
        for (int i = 0; i < ev_kind.size(); i++) begin
            if ((ev_kind[i] == EV_REFILL || ev_kind[i] == EV_LIT) && has) begin
                stim_q.push_back(mk_req(1'b0, 1'b1, byt));
                has = 1'b0;
            end
            if (ev_kind[i] != EV_BUF && ev_kind[i] != EV_COPY) begin
                has = 1'b1;
                byt = packed_q[ev_slot[i]];
            end
            open = 1'b1;
            if (ev_kind[i] == EV_LIT || ev_kind[i] == EV_COPY) begin
                stim_q.push_back(mk_req(1'b0, has, has ? byt : 8'($urandom_range(0, 255))));
                has = 1'b0;
                open = 1'b0;
            end
        end
        if (open) stim_q.push_back(mk_req(1'b0, has, has ? byt : 8'($urandom_range(0, 255))));
        // finishing step, then bytes that must be ignored
        stim_q.push_back(mk_req(1'b0, 1'b0, 8'($urandom_range(0, 255))));
        repeat ($urandom_range(0, 3))
            stim_q.push_back(mk_req(1'b0, 1'($urandom_range(0, 1)),
                                    8'($urandom_range(0, 255))));
    endtask

    task automatic build_noise(input int k);
        stim_q.delete();
        stim_q.push_back(mk_req(1'b1, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))));
        repeat (k)
            stim_q.push_back(mk_req($urandom_range(0, 99) < 3, $urandom_range(0, 99) < 70,
                                    8'($urandom_range(0, 255))));
    endtask

    task automatic send_req(input t_in x);
        int n;
        n = no_idle ? 0 : $urandom_range(0, 4);
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req <= x;
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    // ticks in front of a byte request only drain buffered bits early
    task automatic send_stream();
        foreach (stim_q[i]) begin
            if (stim_q[i].has_byte && !stim_q[i].start_req && $urandom_range(0, 9) == 0)
                send_req(mk_req(1'b0, 1'b0, 8'($urandom_range(0, 255))));
            send_req(stim_q[i]);
        end
        in_valid <= 1'b0;
    endtask

    task automatic drain_and_configure(input logic [CFG_W-1:0] len);
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= len;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_image(input int n, input int mode, input int cap_lit, input int cap_run);
        drain_and_configure(CFG_W'(n));
        encode_image(n, mode, cap_lit, cap_run);
        build_requests($urandom_range(0, 4) != 0);
        if (mode == MODE_CLEAN) n_clean++;
        else n_faulty++;
        send_stream();
    endtask

    task automatic run_noise(input logic [CFG_W-1:0] len, input int k);
        drain_and_configure(len);
        build_noise(k);
        n_noise++;
        send_stream();
    endtask

    initial begin
        int r;
        int n;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_req <= '0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        sent = 0;
        n_clean = 0;
        n_faulty = 0;
        n_noise = 0;
        hold_rx = 1'b0;
        no_idle = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // empty image, single literal, overrun after the last copy,
        // literal overrun, far reference, largest length with noise
        run_image(0, MODE_CLEAN, 8, 12);
        run_image(1, MODE_CLEAN, 8, 12);
        run_image(6, MODE_TAIL_LIT, 2, 4);
        run_image(4, MODE_LIT_OVER, 8, 12);
        run_image(5, MODE_REF_FAR, 2, 3);
        run_noise(24'hffffff, 6);

        // receiver holds off while requests keep coming
        hold_rx = 1'b1;
        run_image(60, MODE_CLEAN, 8, 12);
        run_image(1100, MODE_CLEAN, 300, 1033);

        while (sent < TARGET_REQS) begin
            r = $urandom_range(0, 99);
            no_idle = ($urandom_range(0, 99) < 15);
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
            if (r < 65) run_image(n, MODE_CLEAN, $urandom_range(0, 1) ? 8 : 20,
                                  $urandom_range(0, 1) ? 12 : 60);
            else if (r < 70) run_image(n, MODE_LIT_OVER, 8, 12);
            else if (r < 75) run_image(n < 3 ? 3 : n, MODE_REF_FAR, 8, 12);
            else if (r < 80) run_image(n, MODE_TAIL_LIT, 8, 12);
            else if (r < 85) run_image(n, MODE_CORRUPT, 8, 12);
            else run_noise(CFG_W'($urandom_range(0, 1) ? n : $urandom_range(0, 24'hffffff)),
                           $urandom_range(20, 60));
        end
        no_idle = 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d clean, %0d faulty and %0d noise streams", n_clean, n_faulty,
                 n_noise);
        $display("%0d requests sent, %0d results checked, %0d mismatches", sent,
                 result_count, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS backward_lz_bitstream_depacker");
        end else begin
            $display("FAIL backward_lz_bitstream_depacker");
        end
        $finish;
    end

endmodule

[filelist.f]
src/blzd_pkg.sv
src/blzd_ram.sv
src/blzd_dp.sv
src/blzd_ctrl.sv
src/backward_lz_bitstream_depacker.sv
sim/blzd_checker.sv
sim/tb_backward_lz_bitstream_depacker.sv
